[src/ecpu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpu_pkg
// Types and constants shared by the 8-bit CPU execute unit.
// ----------------------------------------------------------------------------
package ecpu_pkg;

    localparam int DATA_W    = 8;
    localparam int REG_IDX_W = 6;
    localparam int FLAG_W    = 5;
    localparam int PC_W      = 16;

    // non-negative sign-extended immediates reach words 0..31 only
    localparam int DS_WORDS = 32;
    localparam int DS_AW    = $clog2(DS_WORDS);

    localparam int FLAG_C = 4;
    localparam int FLAG_V = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_S = 1;
    localparam int FLAG_Z = 0;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_LDI  = 4'd3,
        OP_BEQZ = 4'd4,
        OP_AND  = 4'd5,
        OP_OR   = 4'd6,
        OP_JR   = 4'd7,
        OP_SAL  = 4'd8,
        OP_SAR  = 4'd9,
        OP_LB   = 4'd10,
        OP_SB   = 4'd11
    } t_op;

    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr;
        logic [DATA_W-1:0]    data;
    } t_rf_wr;

    typedef struct packed {
        logic              en;
        logic [DS_AW-1:0]  addr;
        logic [DATA_W-1:0] data;
    } t_ds_wr;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [FLAG_W-1:0] flags;
        logic              redirect;
        logic [PC_W-1:0]   target;
        logic              addr_err;
        logic              rf_we;
        logic              ds_we;
    } t_exec_res;

endpackage

[src/ecpu_regfile.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpu_regfile
// Register file: synchronous 2-read 1-write memory with per-entry valid bits
// and a last-write bypass for reads issued in the same cycle as a write.
// ----------------------------------------------------------------------------
module ecpu_regfile import ecpu_pkg::*; #(
    parameter int REG_COUNT = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [REG_IDX_W-1:0] i_rd_addr_a,
    input  logic [REG_IDX_W-1:0] i_rd_addr_b,
    input  t_rf_wr               i_wr,
    output logic [DATA_W-1:0]    o_rd_data_a,
    output logic [DATA_W-1:0]    o_rd_data_b
);

    localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam logic [REG_IDX_W:0] CNT = (REG_IDX_W + 1)'(REG_COUNT);

    logic [DATA_W-1:0]    r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;

    logic [DATA_W-1:0]    r_rd_a;
    logic [DATA_W-1:0]    r_rd_b;
    logic                 r_hit_a;
    logic                 r_hit_b;
    logic [REG_IDX_W-1:0] r_addr_a;
    logic [REG_IDX_W-1:0] r_addr_b;

    logic                 r_fwd_vld;
    logic [REG_IDX_W-1:0] r_fwd_addr;
    logic [DATA_W-1:0]    r_fwd_data;

    logic in_a;
    logic in_b;
    logic wr_ok;

    assign in_a  = {1'b0, i_rd_addr_a} < CNT;
    assign in_b  = {1'b0, i_rd_addr_b} < CNT;
    assign wr_ok = i_wr.en && ({1'b0, i_wr.addr} < CNT);

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_a   <= r_mem[i_rd_addr_a[AW-1:0]];
            r_rd_b   <= r_mem[i_rd_addr_b[AW-1:0]];
            r_addr_a <= i_rd_addr_a;
            r_addr_b <= i_rd_addr_b;
        end
        if (wr_ok) begin
            r_fwd_addr <= i_wr.addr;
            r_fwd_data <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_fwd_vld <= 1'b0;
            r_hit_a   <= 1'b0;
            r_hit_b   <= 1'b0;
        end else begin
            if (wr_ok) begin
                r_vld[i_wr.addr[AW-1:0]] <= 1'b1;
                r_fwd_vld                <= 1'b1;
            end
            if (i_rd_en) begin
                r_hit_a <= in_a && r_vld[i_rd_addr_a[AW-1:0]];
                r_hit_b <= in_b && r_vld[i_rd_addr_b[AW-1:0]];
            end
        end
    end

    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_addr_a)) begin
            o_rd_data_a = r_fwd_data;
        end else begin
            o_rd_data_a = r_hit_a ? r_rd_a : '0;
        end
        if (r_fwd_vld && (r_fwd_addr == r_addr_b)) begin
            o_rd_data_b = r_fwd_data;
        end else begin
            o_rd_data_b = r_hit_b ? r_rd_b : '0;
        end
    end

endmodule

[src/ecpu_dstore.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpu_dstore
// Data store: synchronous 1-read 1-write byte memory with per-entry valid
// bits and a last-write bypass.
// ----------------------------------------------------------------------------
module ecpu_dstore import ecpu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [DS_AW-1:0]  i_rd_addr,
    input  t_ds_wr            i_wr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0]   r_mem [DS_WORDS];
    logic [DS_WORDS-1:0] r_vld;

    logic [DATA_W-1:0] r_rd;
    logic              r_hit;
    logic [DS_AW-1:0]  r_addr;

    logic              r_fwd_vld;
    logic [DS_AW-1:0]  r_fwd_addr;
    logic [DATA_W-1:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
            r_fwd_addr       <= i_wr.addr;
            r_fwd_data       <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd   <= r_mem[i_rd_addr];
            r_addr <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_fwd_vld <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
                r_fwd_vld        <= 1'b1;
            end
            if (i_rd_en) begin
                r_hit <= r_vld[i_rd_addr];
            end
        end
    end

    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_addr)) begin
            o_rd_data = r_fwd_data;
        end else begin
            o_rd_data = r_hit ? r_rd : '0;
        end
    end

endmodule

[src/ecpu_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpu_alu
// Execute datapath: arithmetic, logic, shifts, branch target, load/store
// selection and status flag update for one instruction.
// ----------------------------------------------------------------------------
module ecpu_alu import ecpu_pkg::*; (
    input  t_op                  i_op,
    input  logic [REG_IDX_W-1:0] i_field,
    input  logic [PC_W-1:0]      i_pc,
    input  logic [DATA_W-1:0]    i_a,
    input  logic [DATA_W-1:0]    i_b,
    input  logic [DATA_W-1:0]    i_ld_data,
    input  logic [FLAG_W-1:0]    i_flags,
    output t_exec_res            o_res
);

    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] diff;
    logic [DATA_W-1:0] imm;
    logic [2*DATA_W-1:0] prod;
    logic [2:0]        sar_amt;
    logic [DATA_W-1:0] res;
    logic              v_add;
    logic              v_sub;

    assign sum     = {1'b0, i_a} + {1'b0, i_b};
    assign diff    = i_a - i_b;
    assign imm     = {{(DATA_W - REG_IDX_W){i_field[REG_IDX_W-1]}}, i_field};
    assign prod    = i_a * i_b;
    assign sar_amt = (i_field >= REG_IDX_W'(DATA_W)) ? 3'd7 : i_field[2:0];
    assign v_add   = (i_a[DATA_W-1] ^ sum[DATA_W-1]) & (i_b[DATA_W-1] ^ sum[DATA_W-1]);
    assign v_sub   = (i_a[DATA_W-1] ^ i_b[DATA_W-1]) & (i_a[DATA_W-1] ^ diff[DATA_W-1]);

    always_comb begin
        res            = '0;
        o_res          = '0;
        o_res.flags    = i_flags;
        case (i_op)
            OP_ADD: begin
                res         = sum[DATA_W-1:0];
                o_res.rf_we = 1'b1;
            end
            OP_SUB: begin
                res         = diff;
                o_res.rf_we = 1'b1;
            end
            OP_MUL: begin
                res         = prod[DATA_W-1:0];
                o_res.rf_we = 1'b1;
            end
            OP_LDI: begin
                res         = imm;
                o_res.rf_we = 1'b1;
            end
            OP_BEQZ: begin
                if (i_a == '0) begin
                    o_res.redirect = 1'b1;
                    o_res.target   = i_pc + {{(PC_W - REG_IDX_W){i_field[REG_IDX_W-1]}},
                                             i_field} - PC_W'(1);
                end
            end
            OP_AND: begin
                res         = i_a & i_b;
                o_res.rf_we = 1'b1;
            end
            OP_OR: begin
                res         = i_a | i_b;
                o_res.rf_we = 1'b1;
            end
            OP_JR: begin
                o_res.redirect = 1'b1;
                o_res.target   = {i_a, i_b};
            end
            OP_SAL: begin
                res         = (i_field >= REG_IDX_W'(DATA_W)) ? '0 : (i_a << i_field[2:0]);
                o_res.rf_we = 1'b1;
            end
            OP_SAR: begin
                res         = DATA_W'($signed(i_a) >>> sar_amt);
                o_res.rf_we = 1'b1;
            end
            OP_LB: begin
                if (i_field[REG_IDX_W-1]) begin
                    o_res.addr_err = 1'b1;
                end else begin
                    res         = i_ld_data;
                    o_res.rf_we = 1'b1;
                end
            end
            OP_SB: begin
                if (i_field[REG_IDX_W-1]) begin
                    o_res.addr_err = 1'b1;
                end else begin
                    res         = i_a;
                    o_res.ds_we = 1'b1;
                end
            end
            default: begin
                res = '0;
            end
        endcase

        case (i_op)
            OP_ADD: begin
                o_res.flags[FLAG_C] = sum[DATA_W];
                o_res.flags[FLAG_V] = v_add;
                o_res.flags[FLAG_N] = res[DATA_W-1];
                o_res.flags[FLAG_Z] = (res == '0);
                o_res.flags[FLAG_S] = res[DATA_W-1] ^ v_add;
            end
            OP_SUB: begin
                o_res.flags[FLAG_V] = v_sub;
                o_res.flags[FLAG_N] = res[DATA_W-1];
                o_res.flags[FLAG_Z] = (res == '0);
                o_res.flags[FLAG_S] = res[DATA_W-1] ^ v_sub;
            end
            OP_MUL, OP_AND, OP_OR, OP_SAL, OP_SAR: begin
                o_res.flags[FLAG_N] = res[DATA_W-1];
                o_res.flags[FLAG_Z] = (res == '0);
            end
            default: begin
                o_res.flags = i_flags;
            end
        endcase

        o_res.value = res;
    end

endmodule

[src/eight_bit_cpu_execute_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute_unit
// Execute stage of a small 8-bit CPU: register file, status bits and data
// store, one decoded instruction per beat.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  in        i_in_valid / o_in_ready   i_op, i_dest_reg, i_operand_field,
//                                      i_current_pc
//  out       o_out_valid / i_out_ready o_written_value, o_flags, o_redirect,
//                                      o_target_pc, o_address_error
//
//  one beat per cycle unless the output stalls; o_out_valid is registered
//  after the execute stage; the accept reads the register file and data store;
//  execute then writes back; a bypass covers reads issued on the write cycle
//  reset clears the valid bits of both memories at once, no sweep
//  a stalled output holds the execute stage, which then blocks the input
// ----------------------------------------------------------------------------
module eight_bit_cpu_execute_unit import ecpu_pkg::*; #(
    parameter int REG_COUNT = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [3:0]               i_op,
    input  logic [REG_IDX_W-1:0]     i_dest_reg,
    input  logic [REG_IDX_W-1:0]     i_operand_field,
    input  logic [PC_W-1:0]          i_current_pc,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_written_value,
    output logic [FLAG_W-1:0]        o_flags,
    output logic                     o_redirect,
    output logic [PC_W-1:0]          o_target_pc,
    output logic                     o_address_error
);

    logic                 r_e_vld;
    t_op                  r_e_op;
    logic [REG_IDX_W-1:0] r_e_dest;
    logic [REG_IDX_W-1:0] r_e_field;
    logic [PC_W-1:0]      r_e_pc;

    logic [FLAG_W-1:0]    r_flags;

    logic                 r_o_vld;
    t_exec_res            r_o_res;

    logic                 in_acc;
    logic                 e_go;
    logic [DATA_W-1:0]    op_a;
    logic [DATA_W-1:0]    op_b;
    logic [DATA_W-1:0]    ld_data;
    t_exec_res            res;
    t_rf_wr               rf_wr;
    t_ds_wr               ds_wr;

    assign e_go       = r_e_vld && (!r_o_vld || i_out_ready);
    assign o_in_ready = !r_e_vld || e_go;
    assign in_acc     = i_in_valid && o_in_ready;

    assign rf_wr.en   = e_go && res.rf_we;
    assign rf_wr.addr = r_e_dest;
    assign rf_wr.data = res.value;

    assign ds_wr.en   = e_go && res.ds_we;
    assign ds_wr.addr = r_e_field[DS_AW-1:0];
    assign ds_wr.data = res.value;

    ecpu_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_acc),
        .i_rd_addr_a (i_dest_reg),
        .i_rd_addr_b (i_operand_field),
        .i_wr        (rf_wr),
        .o_rd_data_a (op_a),
        .o_rd_data_b (op_b)
    );

    ecpu_dstore u_dstore (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (i_operand_field[DS_AW-1:0]),
        .i_wr      (ds_wr),
        .o_rd_data (ld_data)
    );

    ecpu_alu u_alu (
        .i_op      (r_e_op),
        .i_field   (r_e_field),
        .i_pc      (r_e_pc),
        .i_a       (op_a),
        .i_b       (op_b),
        .i_ld_data (ld_data),
        .i_flags   (r_flags),
        .o_res     (res)
    );

    // execute stage payload and output result
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_e_op    <= t_op'(i_op);
            r_e_dest  <= i_dest_reg;
            r_e_field <= i_operand_field;
            r_e_pc    <= i_current_pc;
        end
        if (e_go) begin
            r_o_res <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_o_vld <= 1'b0;
            r_flags <= '0;
        end else begin
            if (o_in_ready) begin
                r_e_vld <= i_in_valid;
            end
            if (e_go) begin
                r_o_vld <= 1'b1;
                r_flags <= res.flags;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_o_vld;
    assign o_written_value = r_o_res.value;
    assign o_flags         = r_o_res.flags;
    assign o_redirect      = r_o_res.redirect;
    assign o_target_pc     = r_o_res.target;
    assign o_address_error = r_o_res.addr_err;

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_e_vld && r_o_vld && !i_out_ready))
        else $error("input stalled without a blocked execute stage");

    a_exec_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        e_go |=> r_o_vld)
        else $error("executed beat did not reach the output register");

    a_addr_err_no_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_address_error) |-> (o_written_value == '0 && !o_redirect))
        else $error("address error beat carries a value or redirect");

    a_target_only_on_redirect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_redirect) |-> (o_target_pc == '0))
        else $error("target pc set without redirect");

    a_no_write_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (e_go && res.addr_err) |-> (!rf_wr.en && !ds_wr.en))
        else $error("memory write on a faulted load or store");

endmodule
